// ===== rtl/wsmc_pkg.sv =====
// Shared types, suite selectors and codes of the WLAN security mode classifier.
`default_nettype none

package wsmc_pkg;

    typedef enum logic [1:0] {
        KIND_RSN  = 2'd0,
        KIND_WPA  = 2'd1,
        KIND_WAPI = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        MODE_OPEN     = 4'd0,
        MODE_WEP      = 4'd1,
        MODE_8021X    = 4'd2,
        MODE_WPA_EAP  = 4'd3,
        MODE_WPA_PSK  = 4'd4,
        MODE_WPA2_EAP = 4'd5,
        MODE_WPA2_PSK = 4'd6,
        MODE_WAPI     = 4'd7,
        MODE_WAPI_PSK = 4'd8
    } mode_t;

    localparam logic [31:0] SEL_RSN_CCMP  = 32'h000F_AC04;
    localparam logic [31:0] SEL_RSN_EAP   = 32'h000F_AC01;
    localparam logic [31:0] SEL_RSN_PSK   = 32'h000F_AC02;
    localparam logic [31:0] SEL_WPA_EAP   = 32'h0050_F201;
    localparam logic [31:0] SEL_WPA_PSK   = 32'h0050_F202;
    localparam logic [31:0] SEL_WAPI_CERT = 32'h0014_7201;
    localparam logic [31:0] SEL_WAPI_PSK  = 32'h0014_7202;

    localparam int F_RSN_PSK   = 0;
    localparam int F_RSN_EAP   = 1;
    localparam int F_RSN_GCCMP = 2;
    localparam int F_RSN_PCCMP = 3;
    localparam int F_WPA_PSK   = 4;
    localparam int F_WPA_EAP   = 5;
    localparam int F_WAPI_CERT = 6;
    localparam int F_WAPI_PSK  = 7;

    localparam logic [7:0]  POS_LIMIT       = 8'hFF;
    localparam logic [10:0] RSN_GROUP_END   = 11'd5;
    localparam logic [10:0] RSN_PW_COUNT    = 11'd6;
    localparam logic [10:0] RSN_PW_BASE     = 11'd8;
    localparam logic [10:0] WPA_PW_COUNT    = 11'd10;
    localparam logic [10:0] WPA_PW_BASE     = 11'd12;
    localparam logic [10:0] WAPI_AKM_COUNT  = 11'd2;
    localparam logic [10:0] WAPI_AKM_BASE   = 11'd4;
    localparam logic [10:0] AKM_SUITE_SKIP  = 11'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       start;
        logic       fend;
        logic       privacy;
    } item_t;

    typedef struct packed {
        logic [2:0] seen_next;
        logic [7:0] flags_next;
        logic [2:0] seen;
        logic [7:0] flags;
    } trk_stat_t;

    // True when offset p is the last byte of one of n four-byte suites starting at base.
    function automatic logic slot_end(logic [10:0] p, logic [10:0] base, logic [7:0] n);
        logic [10:0] d;
        logic        hit;
        d   = p - base - 11'd3;
        hit = 1'b0;
        if (p >= base + 11'd3) begin
            hit = (d[1:0] == 2'b00) && (d[10:2] < {1'b0, n});
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/wsmc_tracker.sv =====
// Per-element byte tracker: offset, suite counts, selector window and match flags.
`default_nettype none

module wsmc_tracker (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               fire,
    input  wire wsmc_pkg::item_t    item,
    output wsmc_pkg::trk_stat_t     stat
);

    logic [7:0]          pos_reg, pos_next;
    logic [23:0]         recent_reg, recent_next;
    logic [7:0]          pw_reg, pw_next;
    logic [7:0]          akm_reg, akm_next;
    wsmc_pkg::kind_t     active_reg, active_next;
    logic [2:0]          seen_reg, seen_next;
    logic [7:0]          flags_reg, flags_next;

    logic [7:0]          e_pos;
    logic [23:0]         e_recent;
    logic [7:0]          e_pw;
    logic [7:0]          e_akm;
    logic                take;
    logic [31:0]         w;
    logic [10:0]         p;
    logic [10:0]         akm_at;

    always_comb begin
        e_pos       = pos_reg;
        e_recent    = recent_reg;
        e_pw        = pw_reg;
        e_akm       = akm_reg;
        seen_next   = seen_reg;
        active_next = active_reg;
        flags_next  = flags_reg;
        take        = 1'b0;
        if (item.kind != wsmc_pkg::KIND_NONE) begin
            if (item.start) begin
                if (seen_reg[item.kind]) begin
                    active_next = wsmc_pkg::KIND_NONE;
                end else begin
                    seen_next[item.kind] = 1'b1;
                    active_next          = wsmc_pkg::kind_t'(item.kind);
                    e_pos                = '0;
                    e_recent             = '0;
                    e_pw                 = '0;
                    e_akm                = '0;
                end
            end
            take = (item.kind == active_next) && (e_pos != wsmc_pkg::POS_LIMIT);
        end

        w           = {e_recent, item.data};
        p           = {3'b000, e_pos};
        pos_next    = e_pos;
        recent_next = e_recent;
        pw_next     = e_pw;
        akm_next    = e_akm;
        akm_at      = '0;

        if (take) begin
            case (wsmc_pkg::kind_t'(item.kind))
                wsmc_pkg::KIND_RSN: begin
                    if (p == wsmc_pkg::RSN_GROUP_END && w == wsmc_pkg::SEL_RSN_CCMP) begin
                        flags_next[wsmc_pkg::F_RSN_GCCMP] = 1'b1;
                    end
                    if (p == wsmc_pkg::RSN_PW_COUNT) begin
                        pw_next = item.data;
                    end
                    if (wsmc_pkg::slot_end(p, wsmc_pkg::RSN_PW_BASE, e_pw)
                        && w == wsmc_pkg::SEL_RSN_CCMP) begin
                        flags_next[wsmc_pkg::F_RSN_PCCMP] = 1'b1;
                    end
                    akm_at = wsmc_pkg::RSN_PW_BASE + {1'b0, e_pw, 2'b00};
                    if (p == akm_at) begin
                        akm_next = item.data;
                    end
                    if (wsmc_pkg::slot_end(p, akm_at + wsmc_pkg::AKM_SUITE_SKIP, e_akm)) begin
                        if (w == wsmc_pkg::SEL_RSN_PSK) flags_next[wsmc_pkg::F_RSN_PSK] = 1'b1;
                        if (w == wsmc_pkg::SEL_RSN_EAP) flags_next[wsmc_pkg::F_RSN_EAP] = 1'b1;
                    end
                end
                wsmc_pkg::KIND_WPA: begin
                    if (p == wsmc_pkg::WPA_PW_COUNT) begin
                        pw_next = item.data;
                    end
                    akm_at = wsmc_pkg::WPA_PW_BASE + {1'b0, e_pw, 2'b00};
                    if (p == akm_at) begin
                        akm_next = item.data;
                    end
                    if (wsmc_pkg::slot_end(p, akm_at + wsmc_pkg::AKM_SUITE_SKIP, e_akm)) begin
                        if (w == wsmc_pkg::SEL_WPA_PSK) flags_next[wsmc_pkg::F_WPA_PSK] = 1'b1;
                        if (w == wsmc_pkg::SEL_WPA_EAP) flags_next[wsmc_pkg::F_WPA_EAP] = 1'b1;
                    end
                end
                default: begin
                    if (p == wsmc_pkg::WAPI_AKM_COUNT) begin
                        akm_next = item.data;
                    end
                    if (wsmc_pkg::slot_end(p, wsmc_pkg::WAPI_AKM_BASE, e_akm)) begin
                        if (w == wsmc_pkg::SEL_WAPI_CERT) begin
                            flags_next[wsmc_pkg::F_WAPI_CERT] = 1'b1;
                        end
                        if (w == wsmc_pkg::SEL_WAPI_PSK) begin
                            flags_next[wsmc_pkg::F_WAPI_PSK] = 1'b1;
                        end
                    end
                end
            endcase
            recent_next = w[23:0];
            pos_next    = e_pos + 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            recent_reg <= '0;
            pw_reg     <= '0;
            akm_reg    <= '0;
            active_reg <= wsmc_pkg::KIND_NONE;
            seen_reg   <= '0;
            flags_reg  <= '0;
        end else if (fire) begin
            if (item.fend) begin
                pos_reg    <= '0;
                recent_reg <= '0;
                pw_reg     <= '0;
                akm_reg    <= '0;
                active_reg <= wsmc_pkg::KIND_NONE;
                seen_reg   <= '0;
                flags_reg  <= '0;
            end else begin
                pos_reg    <= pos_next;
                recent_reg <= recent_next;
                pw_reg     <= pw_next;
                akm_reg    <= akm_next;
                active_reg <= active_next;
                seen_reg   <= seen_next;
                flags_reg  <= flags_next;
            end
        end
    end

    assign stat.seen_next  = seen_next;
    assign stat.flags_next = flags_next;
    assign stat.seen       = seen_reg;
    assign stat.flags      = flags_reg;

endmodule

`default_nettype wire

// ===== rtl/wsmc_classify.sv =====
// Priority rules that map seen elements, match flags and privacy to a security mode.
`default_nettype none

module wsmc_classify (
    input  wire logic [2:0]      seen,
    input  wire logic [7:0]      flags,
    input  wire logic            privacy,
    output wsmc_pkg::mode_t      mode
);

    logic rsn, wpa, wapi, wpa2;

    always_comb begin
        rsn  = seen[wsmc_pkg::KIND_RSN];
        wpa  = seen[wsmc_pkg::KIND_WPA];
        wapi = seen[wsmc_pkg::KIND_WAPI];
        wpa2 = flags[wsmc_pkg::F_RSN_GCCMP] && flags[wsmc_pkg::F_RSN_PCCMP];
        if (!privacy) begin
            mode = (!rsn && !wpa) ? wsmc_pkg::MODE_OPEN : wsmc_pkg::MODE_8021X;
        end else if (!rsn && !wpa && !wapi) begin
            mode = wsmc_pkg::MODE_WEP;
        end else if (rsn && flags[wsmc_pkg::F_RSN_PSK]) begin
            mode = wpa2 ? wsmc_pkg::MODE_WPA2_PSK : wsmc_pkg::MODE_WPA_PSK;
        end else if (rsn && flags[wsmc_pkg::F_RSN_EAP]) begin
            mode = wpa2 ? wsmc_pkg::MODE_WPA2_EAP : wsmc_pkg::MODE_WPA_EAP;
        end else if (wpa && flags[wsmc_pkg::F_WPA_PSK]) begin
            mode = wsmc_pkg::MODE_WPA_PSK;
        end else if (wpa && flags[wsmc_pkg::F_WPA_EAP]) begin
            mode = wsmc_pkg::MODE_WPA_EAP;
        end else if (wapi && flags[wsmc_pkg::F_WAPI_CERT]) begin
            mode = wsmc_pkg::MODE_WAPI;
        end else if (wapi && flags[wsmc_pkg::F_WAPI_PSK]) begin
            mode = wsmc_pkg::MODE_WAPI_PSK;
        end else begin
            mode = wsmc_pkg::MODE_8021X;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wlan_security_mode_classifier_unit.sv =====
// Top level of the WLAN security mode classifier: input register, tracker, result register.
// A frame-end item passes the input register, then the result register, before m_valid rises.
// Throughput: one item per cycle; the input register stalls only on a frame-end item while a result waits on m_ready.
// The per-item work is one pass through the tracker and priority logic.
// Reset: synchronous, active low; clears the tracker to no element seen and empties both registers.
`default_nettype none

module wlan_security_mode_classifier_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_ie_kind,
    input  wire logic [7:0] s_ie_byte,
    input  wire logic       s_ie_start,
    input  wire logic       s_frame_end,
    input  wire logic       s_privacy,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [3:0]      m_security_mode
);

    logic                 in_valid_reg;
    wsmc_pkg::item_t      in_item_reg;
    logic                 m_valid_reg, m_valid_next;
    logic [3:0]           mode_reg;
    logic                 advance;
    wsmc_pkg::trk_stat_t  trk;
    wsmc_pkg::mode_t      mode;

    assign advance = in_valid_reg && (!in_item_reg.fend || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg.kind    <= s_ie_kind;
            in_item_reg.data    <= s_ie_byte;
            in_item_reg.start   <= s_ie_start;
            in_item_reg.fend    <= s_frame_end;
            in_item_reg.privacy <= s_privacy;
        end
    end

    wsmc_tracker u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .item    (in_item_reg),
        .stat    (trk)
    );

    wsmc_classify u_classify (
        .seen    (trk.seen_next),
        .flags   (trk.flags_next),
        .privacy (in_item_reg.privacy),
        .mode    (mode)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance && in_item_reg.fend) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_item_reg.fend) begin
            mode_reg <= mode;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_security_mode = mode_reg;

    a_frame_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_item_reg.fend |=> trk.seen == 3'b000 && trk.flags == 8'h00)
        else $error("tracker state not cleared after frame end");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(advance && in_item_reg.fend))
        else $error("result raised without a frame-end item");

    a_flags_need_rsn: assert property (@(posedge aclk) disable iff (!aresetn)
        trk.flags[3:0] != 4'h0 |-> trk.seen[wsmc_pkg::KIND_RSN])
        else $error("RSN match flag without an RSN element");

    a_open_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_item_reg.fend && !in_item_reg.privacy && trk.seen_next[1:0] == 2'b00
        |=> m_security_mode == wsmc_pkg::MODE_OPEN)
        else $error("open network not reported as open");

endmodule

`default_nettype wire

// ===== verif/wlan_security_mode_classifier_unit_test.sv =====
// Testbench of the security mode classifier: element byte streams checked against a local predictor.
module wlan_security_mode_classifier_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wsmc_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEM_TARGET = 1350;
    localparam int FRAME_TARGET = 14;
    localparam logic [31:0] WPA_IE_HEADER = 32'h0050_F201;
    localparam logic [31:0] SEL_WPA_CCMP  = 32'h0050_F204;
    localparam logic [31:0] SEL_RSN_TKIP  = 32'h000F_AC02;
    localparam logic [31:0] SEL_AKM_OTHER = 32'h000F_AC08;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_ie_kind = KIND_NONE;
    logic [7:0] s_ie_byte = 8'h00;
    logic       s_ie_start = 1'b0;
    logic       s_frame_end = 1'b0;
    logic       s_privacy = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [3:0] m_security_mode;

    logic [7:0]  trk_pos;
    logic [23:0] trk_window;
    logic [7:0]  trk_pw_cnt;
    logic [7:0]  trk_akm_cnt;
    kind_t       trk_active;
    logic [2:0]  trk_seen;
    logic [7:0]  trk_flags;

    mode_t      expected_modes[$];
    logic [7:0] body[$];
    bit         idle_on = 1'b1;
    int         hold_requests = 0;
    int         hold_taken = 0;
    int         hold_left = 0;
    int         items_sent = 0;
    int         fail_count = 0;
    int         quiet_cycles = 0;

    wlan_security_mode_classifier_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_ie_kind       (s_ie_kind),
        .s_ie_byte       (s_ie_byte),
        .s_ie_start      (s_ie_start),
        .s_frame_end     (s_frame_end),
        .s_privacy       (s_privacy),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_security_mode (m_security_mode)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic void tracker_clear();
        trk_pos     = 8'h00;
        trk_window  = 24'h000000;
        trk_pw_cnt  = 8'h00;
        trk_akm_cnt = 8'h00;
        trk_active  = KIND_NONE;
        trk_seen    = 3'b000;
        trk_flags   = 8'h00;
    endfunction

    function automatic bit suite_tail(int unsigned p, int unsigned base, int unsigned n);
        if (p < base + 3) return 1'b0;
        return ((p - base - 3) % 4 == 0) && ((p - base - 3) / 4 < n);
    endfunction

    function automatic void akm_match(int unsigned p, int unsigned base, logic [31:0] w,
                                      logic [31:0] sel_a, int flag_a,
                                      logic [31:0] sel_b, int flag_b);
        if (suite_tail(p, base, int'(trk_akm_cnt))) begin
            if (w == sel_a) trk_flags[flag_a] = 1'b1;
            if (w == sel_b) trk_flags[flag_b] = 1'b1;
        end
    endfunction

    function automatic void absorb_byte(kind_t k, logic [7:0] b);
        int unsigned p;
        int unsigned akm_at;
        logic [31:0] w;
        p = int'(trk_pos);
        w = {trk_window, b};
        if (trk_pos != POS_LIMIT) begin
            case (k)
                KIND_RSN: begin
                    if (p == RSN_GROUP_END && w == SEL_RSN_CCMP) trk_flags[F_RSN_GCCMP] = 1'b1;
                    if (p == RSN_PW_COUNT) trk_pw_cnt = b;
                    if (suite_tail(p, RSN_PW_BASE, int'(trk_pw_cnt)) && w == SEL_RSN_CCMP)
                        trk_flags[F_RSN_PCCMP] = 1'b1;
                    akm_at = RSN_PW_BASE + 4 * int'(trk_pw_cnt);
                    if (p == akm_at) trk_akm_cnt = b;
                    akm_match(p, akm_at + AKM_SUITE_SKIP, w,
                              SEL_RSN_PSK, F_RSN_PSK, SEL_RSN_EAP, F_RSN_EAP);
                end
                KIND_WPA: begin
                    if (p == WPA_PW_COUNT) trk_pw_cnt = b;
                    akm_at = WPA_PW_BASE + 4 * int'(trk_pw_cnt);
                    if (p == akm_at) trk_akm_cnt = b;
                    akm_match(p, akm_at + AKM_SUITE_SKIP, w,
                              SEL_WPA_PSK, F_WPA_PSK, SEL_WPA_EAP, F_WPA_EAP);
                end
                default: begin
                    if (p == WAPI_AKM_COUNT) trk_akm_cnt = b;
                    akm_match(p, WAPI_AKM_BASE, w,
                              SEL_WAPI_CERT, F_WAPI_CERT, SEL_WAPI_PSK, F_WAPI_PSK);
                end
            endcase
            trk_window = w[23:0];
            trk_pos    = trk_pos + 8'd1;
        end
    endfunction

    function automatic mode_t classify_mode(logic priv);
        logic  rsn;
        logic  wpa;
        logic  wapi;
        logic  wpa2;
        mode_t m;
        rsn  = trk_seen[KIND_RSN];
        wpa  = trk_seen[KIND_WPA];
        wapi = trk_seen[KIND_WAPI];
        wpa2 = trk_flags[F_RSN_GCCMP] && trk_flags[F_RSN_PCCMP];
        if (!priv) m = (!rsn && !wpa) ? MODE_OPEN : MODE_8021X;
        else if (!rsn && !wpa && !wapi) m = MODE_WEP;
        else if (rsn && trk_flags[F_RSN_PSK]) m = wpa2 ? MODE_WPA2_PSK : MODE_WPA_PSK;
        else if (rsn && trk_flags[F_RSN_EAP]) m = wpa2 ? MODE_WPA2_EAP : MODE_WPA_EAP;
        else if (wpa && trk_flags[F_WPA_PSK]) m = MODE_WPA_PSK;
        else if (wpa && trk_flags[F_WPA_EAP]) m = MODE_WPA_EAP;
        else if (wapi && trk_flags[F_WAPI_CERT]) m = MODE_WAPI;
        else if (wapi && trk_flags[F_WAPI_PSK]) m = MODE_WAPI_PSK;
        else m = MODE_8021X;
        return m;
    endfunction

    function automatic void predict_transfer(logic [1:0] kind, logic [7:0] data, logic start,
                                             logic fend, logic priv);
        if (kind != KIND_NONE) begin
            if (start) begin
                if (trk_seen[kind]) begin
                    trk_active = KIND_NONE;
                end else begin
                    trk_seen[kind] = 1'b1;
                    trk_active     = kind_t'(kind);
                    trk_pos        = 8'h00;
                    trk_window     = 24'h000000;
                    trk_pw_cnt     = 8'h00;
                    trk_akm_cnt    = 8'h00;
                end
            end
            if (kind == trk_active) absorb_byte(kind_t'(kind), data);
        end
        if (fend) begin
            expected_modes.push_back(classify_mode(priv));
            tracker_clear();
        end
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_modes.size() == 0) begin
                report_mismatch($sformatf("unexpected security_mode %0d", m_security_mode));
            end else begin
                if (m_security_mode !== expected_modes[0])
                    report_mismatch($sformatf("security_mode got %0d expected %0d",
                                              m_security_mode, expected_modes[0]));
                void'(expected_modes.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_taken != hold_requests) begin
            hold_taken = hold_requests;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (idle_on) begin
            m_ready <= ($urandom_range(99) >= 27);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic send_item(logic [1:0] kind, logic [7:0] data, logic start, logic fend,
                             logic priv);
        while (idle_on && $urandom_range(99) < 27) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_ie_kind   <= kind;
        s_ie_byte   <= data;
        s_ie_start  <= start;
        s_frame_end <= fend;
        s_privacy   <= priv;
        do @(posedge aclk); while (!s_ready);
        predict_transfer(kind, data, start, fend, priv);
        items_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_modes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic put_word(logic [31:0] w);
        for (int i = 3; i >= 0; i--) body.push_back(w[8*i +: 8]);
    endtask

    task automatic put_count(int n, bit scramble);
        body.push_back((scramble && $urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'(n));
        body.push_back(8'($urandom_range(255)));
    endtask

    task automatic truncate_body(int n);
        while (body.size() > n) void'(body.pop_back());
    endtask

    function automatic logic [31:0] pick_sel(kind_t k, bit akm);
        int unsigned r;
        logic [31:0] s;
        r = $urandom_range(9);
        case (k)
            KIND_RSN: s = akm ? ($urandom_range(1) ? SEL_RSN_PSK : SEL_RSN_EAP) : SEL_RSN_CCMP;
            KIND_WPA: s = akm ? ($urandom_range(1) ? SEL_WPA_PSK : SEL_WPA_EAP) : SEL_WPA_CCMP;
            default:  s = $urandom_range(1) ? SEL_WAPI_CERT : SEL_WAPI_PSK;
        endcase
        if (r == 5 || r == 6) begin
            case ($urandom_range(6))
                0: s = SEL_RSN_CCMP;
                1: s = SEL_RSN_EAP;
                2: s = SEL_RSN_PSK;
                3: s = SEL_WPA_EAP;
                4: s = SEL_WPA_PSK;
                5: s = SEL_WAPI_CERT;
                default: s = SEL_WAPI_PSK;
            endcase
        end else if (r == 7) begin
            s = s ^ (32'd1 << $urandom_range(31));
        end else if (r >= 8) begin
            s = $urandom;
        end
        return s;
    endfunction

    task automatic build_element(kind_t k, logic [31:0] group, int n_pw, logic [31:0] pw,
                                 int n_akm, logic [31:0] akm, bit scramble);
        body.delete();
        if (k == KIND_WPA) put_word(WPA_IE_HEADER);
        body.push_back(8'h01);
        body.push_back(8'h00);
        if (k == KIND_WAPI) begin
            put_count(n_akm, scramble);
            repeat (n_akm) put_word(scramble ? pick_sel(k, 1'b1) : akm);
        end else begin
            put_word(group);
            put_count(n_pw, scramble);
            repeat (n_pw) put_word(scramble ? pick_sel(k, 1'b0) : pw);
            put_count(n_akm, scramble);
            repeat (n_akm) put_word(scramble ? pick_sel(k, 1'b1) : akm);
        end
        body.push_back(8'($urandom_range(255)));
        body.push_back(8'($urandom_range(255)));
    endtask

    task automatic send_body(kind_t k, bit fend_last, logic priv);
        foreach (body[i])
            send_item(k, body[i], i == 0, fend_last && i == body.size() - 1, priv);
    endtask

    task automatic finish_frame(logic priv);
        send_item(KIND_NONE, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1, priv);
    endtask

    task automatic element_frame(kind_t k, logic [31:0] group, int n_pw, logic [31:0] pw,
                                 int n_akm, logic [31:0] akm, logic priv);
        build_element(k, group, n_pw, pw, n_akm, akm, 1'b0);
        send_body(k, 1'b0, priv);
        finish_frame(priv);
    endtask

    task automatic test_bare_frames();
        finish_frame(1'b0);
        finish_frame(1'b1);
        send_item(KIND_NONE, 8'hFF, 1'b0, 1'b0, 1'b1);
        finish_frame(1'b1);
        element_frame(KIND_RSN, SEL_RSN_CCMP, 1, SEL_RSN_CCMP, 1, SEL_RSN_PSK, 1'b0);
    endtask

    task automatic test_rsn_modes();
        element_frame(KIND_RSN, SEL_RSN_CCMP, 1, SEL_RSN_CCMP, 1, SEL_RSN_PSK, 1'b1);
        element_frame(KIND_RSN, SEL_RSN_CCMP, 2, SEL_RSN_CCMP, 1, SEL_RSN_EAP, 1'b1);
        element_frame(KIND_RSN, SEL_RSN_TKIP, 1, SEL_RSN_CCMP, 1, SEL_RSN_PSK, 1'b1);
        element_frame(KIND_RSN, SEL_RSN_CCMP, 1, SEL_RSN_TKIP, 1, SEL_RSN_EAP, 1'b1);
        element_frame(KIND_RSN, SEL_RSN_CCMP, 0, SEL_RSN_CCMP, 2, SEL_AKM_OTHER, 1'b1);
    endtask

    task automatic test_wpa_wapi_modes();
        element_frame(KIND_WPA, SEL_WPA_CCMP, 1, SEL_WPA_CCMP, 1, SEL_WPA_PSK, 1'b1);
        element_frame(KIND_WPA, SEL_WPA_CCMP, 2, SEL_WPA_CCMP, 1, SEL_WPA_EAP, 1'b1);
        element_frame(KIND_WAPI, 32'h0, 0, 32'h0, 1, SEL_WAPI_CERT, 1'b1);
        element_frame(KIND_WAPI, 32'h0, 0, 32'h0, 2, SEL_WAPI_PSK, 1'b1);
        element_frame(KIND_WAPI, 32'h0, 0, 32'h0, 1, SEL_WAPI_CERT, 1'b0);
        build_element(KIND_RSN, SEL_RSN_CCMP, 1, SEL_RSN_CCMP, 1, SEL_AKM_OTHER, 1'b0);
        send_body(KIND_RSN, 1'b0, 1'b1);
        build_element(KIND_WPA, SEL_WPA_CCMP, 1, SEL_WPA_CCMP, 1, SEL_WPA_PSK, 1'b0);
        send_body(KIND_WPA, 1'b0, 1'b1);
        build_element(KIND_WAPI, 32'h0, 0, 32'h0, 1, SEL_WAPI_CERT, 1'b0);
        send_body(KIND_WAPI, 1'b0, 1'b1);
        finish_frame(1'b1);
    endtask

    task automatic test_repeated_and_stray();
        build_element(KIND_RSN, SEL_RSN_CCMP, 1, SEL_RSN_CCMP, 1, SEL_AKM_OTHER, 1'b0);
        send_body(KIND_RSN, 1'b0, 1'b1);
        build_element(KIND_RSN, SEL_RSN_CCMP, 1, SEL_RSN_CCMP, 1, SEL_RSN_PSK, 1'b0);
        send_body(KIND_RSN, 1'b0, 1'b1);
        finish_frame(1'b1);
        build_element(KIND_RSN, SEL_RSN_CCMP, 1, SEL_RSN_CCMP, 1, SEL_RSN_PSK, 1'b0);
        foreach (body[i]) begin
            if (i == 9) begin
                send_item(KIND_WPA, 8'hAA, 1'b0, 1'b0, 1'b1);
                send_item(KIND_NONE, 8'h55, 1'b1, 1'b0, 1'b1);
                send_item(KIND_WAPI, 8'h00, 1'b0, 1'b0, 1'b1);
            end
            send_item(KIND_RSN, body[i], i == 0, 1'b0, 1'b1);
        end
        finish_frame(1'b1);
        foreach (body[i]) send_item(KIND_RSN, body[i], i == 0 || i == 8, 1'b0, 1'b1);
        finish_frame(1'b1);
    endtask

    task automatic test_short_and_long();
        build_element(KIND_RSN, SEL_RSN_CCMP, 1, SEL_RSN_CCMP, 1, SEL_RSN_PSK, 1'b0);
        truncate_body(body.size() - 3);
        send_body(KIND_RSN, 1'b0, 1'b1);
        finish_frame(1'b1);
        build_element(KIND_RSN, SEL_RSN_CCMP, 1, SEL_RSN_CCMP, 1, SEL_RSN_PSK, 1'b0);
        truncate_body(7);
        send_body(KIND_RSN, 1'b0, 1'b1);
        finish_frame(1'b1);
        build_element(KIND_RSN, SEL_RSN_CCMP, 2, SEL_RSN_CCMP, 1, SEL_RSN_PSK, 1'b0);
        body[6] = 8'hFF;
        send_body(KIND_RSN, 1'b0, 1'b1);
        finish_frame(1'b1);
        element_frame(KIND_RSN, SEL_RSN_CCMP, 70, SEL_RSN_CCMP, 1, SEL_RSN_PSK, 1'b1);
        build_element(KIND_WAPI, 32'h0, 0, 32'h0, 1, SEL_WAPI_PSK, 1'b0);
        send_body(KIND_WAPI, 1'b1, 1'b1);
        build_element(KIND_RSN, SEL_RSN_CCMP, 1, SEL_RSN_CCMP, 1, SEL_RSN_EAP, 1'b0);
        truncate_body(body.size() - 2);
        send_body(KIND_RSN, 1'b1, 1'b1);
    endtask

    task automatic test_output_stall();
        hold_requests++;
        repeat (16) finish_frame(1'($urandom_range(1)));
        drain_results();
    endtask

    task automatic random_frame();
        int    n_el;
        kind_t k;
        logic  priv;
        bit    end_on_byte;
        bit    last_fend;
        priv        = ($urandom_range(9) != 0);
        n_el        = $urandom_range(0, 3);
        end_on_byte = 1'($urandom_range(1));
        last_fend   = 1'b0;
        for (int e = 0; e < n_el; e++) begin
            k = kind_t'($urandom_range(2));
            build_element(k, pick_sel(k, 1'b0),
                          ($urandom_range(99) == 0) ? $urandom_range(55, 70) : $urandom_range(2),
                          32'h0, $urandom_range(2), 32'h0, 1'b1);
            if ($urandom_range(6) == 0) truncate_body($urandom_range(0, body.size() - 1));
            if ($urandom_range(4) == 0)
                send_item(2'($urandom_range(3)), 8'($urandom_range(255)),
                          1'($urandom_range(1)), 1'b0, priv);
            last_fend = end_on_byte && e == n_el - 1 && body.size() != 0;
            send_body(k, last_fend, priv);
        end
        if (!last_fend) finish_frame(priv);
    endtask

    task automatic test_random_frames();
        int frame_no;
        frame_no = 0;
        while (items_sent < ITEM_TARGET || frame_no < FRAME_TARGET) begin
            idle_on = !(frame_no >= 3 && frame_no < 13);
            random_frame();
            frame_no++;
        end
        idle_on = 1'b1;
    endtask

    initial begin
        tracker_clear();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_bare_frames();
        test_rsn_modes();
        test_wpa_wapi_modes();
        test_repeated_and_stray();
        test_short_and_long();
        test_output_stall();
        test_random_frames();
        drain_results();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
